// ----- hdl/tccs_pkg.sv -----
// Shared types and constants for the text console block.
// Used by the top level, its port checker and the testbench; depends on nothing.
package tccs_pkg;

  // Field widths of the input and result items
  localparam int CMD_W      = 2;
  localparam int CHAR_W     = 8;
  localparam int ROW_SEL_W  = 4;
  localparam int COL_SEL_W  = 6;
  localparam int CELL_W     = 8;
  localparam int CUR_ROW_W  = 4;
  localparam int CUR_COL_W  = 7;

  // Packed stream widths (padded to whole bytes)
  localparam int IN_FIELDS_W  = CHAR_W + ROW_SEL_W + COL_SEL_W;
  localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = CELL_W + CUR_ROW_W + CUR_COL_W + 1;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Control characters recognized on a put
  localparam logic [CHAR_W-1:0] CH_NUL = 8'h00;
  localparam logic [CHAR_W-1:0] CH_TAB = 8'h09;
  localparam logic [CHAR_W-1:0] CH_NL  = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR  = 8'h0D;

  // Columns advanced by a tab
  localparam int TAB_STEP = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUT   = 2'd0,
    CMD_READ  = 2'd1,
    CMD_SET   = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_t;

endpackage

// ----- hdl/tccs_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Holds the character cells of the console; no dependencies.
module tccs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- hdl/text_console_cursor_scroll_top.sv -----
// Text console: character cell store, cursor and ring-offset scrolling.
// Depends on tccs_pkg and the tccs_ram cell memory.
//
// Item flow: one item is in work at a time and in_tready is high only
// between items. A set cursor and a put that writes nothing go straight to
// the done state, a read goes through the read state and a put that writes
// a character through the write state; a scrolling put first clears the new
// bottom row and clear all clears every cell; these sweeps write one cell per
// cycle through the single write port of the cell memory. After reset the
// block clears every cell before it first raises in_tready. A finished result
// sits in the output register, so the next item can be taken while it waits.
module text_console_cursor_scroll_top
  import tccs_pkg::*;
#(
  parameter int ROWS = 16,
  parameter int COLS = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // in_tdata: char_code [7:0], row_sel [11:8], col_sel [17:12], zero pad
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // in_tuser: command [1:0]
  input  logic [CMD_W-1:0]      in_tuser,
  // out_tdata: cell_char [7:0], cur_row [11:8], cur_col [18:12],
  //            scrolled [19], zero pad
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata
);

  localparam int RW    = $clog2(ROWS);
  localparam int CW    = $clog2(COLS + 1);
  localparam int CTW   = CW + 2;
  localparam int DEPTH = ROWS * COLS;
  localparam int AW    = $clog2(DEPTH);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_CLR  = 5'b00010,
    ST_WR   = 5'b00100,
    ST_RD   = 5'b01000,
    ST_DONE = 5'b10000
  } state_t;

  state_t              state_r, state_nxt;
  logic [RW-1:0]       cur_row_r, cur_row_nxt;
  logic [CW-1:0]       cur_col_r, cur_col_nxt;
  logic [RW-1:0]       top_r, top_nxt;
  logic [CHAR_W-1:0]   ch_r, ch_nxt;
  logic [CW-1:0]       wr_col_r, wr_col_nxt;
  logic                wr_pend_r, wr_pend_nxt;
  logic                scr_r, scr_nxt;
  logic [CELL_W-1:0]   cell_r, cell_nxt;
  logic                rd_zero_r, rd_zero_nxt;
  logic                init_r, init_nxt;
  logic [AW-1:0]       clr_addr_r, clr_addr_nxt;
  logic [AW-1:0]       clr_last_r, clr_last_nxt;

  logic                out_valid_r;
  logic [CELL_W-1:0]   out_cell_r;
  logic [CUR_ROW_W-1:0] out_row_r;
  logic [CUR_COL_W-1:0] out_col_r;
  logic                out_scr_r;
  logic                out_load;

  // Cell memory ports
  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [CHAR_W-1:0]   ram_wdata;
  logic [CHAR_W-1:0]   ram_rdata;

  // Input fields
  cmd_t                in_cmd;
  logic [CHAR_W-1:0]   in_char;
  logic [ROW_SEL_W-1:0] in_row;
  logic [COL_SEL_W-1:0] in_col;
  logic                in_accept;

  assign in_cmd    = cmd_t'(in_tuser);
  assign in_char   = in_tdata[CHAR_W-1:0];
  assign in_row    = in_tdata[CHAR_W +: ROW_SEL_W];
  assign in_col    = in_tdata[CHAR_W + ROW_SEL_W +: COL_SEL_W];
  assign in_tready = (state_r == ST_IDLE);
  assign in_accept = in_tvalid && in_tready;

  // Saturate and range-check the selected row and column
  logic [RW-1:0] sel_row;
  logic [CW-1:0] sel_col_set;
  logic [CW-1:0] sel_col_rd;
  logic          sel_col_oor;

  assign sel_row     = (int'(in_row) > ROWS - 1) ? RW'(ROWS - 1) : RW'(in_row);
  assign sel_col_oor = (int'(in_col) > COLS - 1);
  assign sel_col_set = sel_col_oor ? CW'(COLS - 1) : CW'(in_col);
  assign sel_col_rd  = sel_col_oor ? '0 : CW'(in_col);

  // Shared address unit: screen row to ring row, then row * COLS + column
  logic [RW-1:0] unit_row;
  logic [CW-1:0] unit_col;
  logic [RW:0]   phys_sum;
  logic [RW-1:0] phys_row;
  logic [AW-1:0] unit_addr;

  assign unit_row  = (state_r == ST_WR) ? cur_row_r : sel_row;
  assign unit_col  = (state_r == ST_WR) ? wr_col_r : sel_col_rd;
  assign phys_sum  = {1'b0, top_r} + {1'b0, unit_row};
  assign phys_row  = (phys_sum >= (RW + 1)'(ROWS)) ? RW'(phys_sum - (RW + 1)'(ROWS))
                                                    : RW'(phys_sum);
  assign unit_addr = AW'(phys_row) * AW'(COLS) + AW'(unit_col);

  // Put: cursor motion, wrap and scroll decision
  logic [CTW-1:0] pt_col;
  logic [RW-1:0]  pt_row;
  logic [RW-1:0]  pt_top;
  logic           pt_adv;
  logic           pt_wr;
  logic           pt_scr;

  always_comb begin
    pt_col = CTW'(cur_col_r);
    pt_row = cur_row_r;
    pt_top = top_r;
    pt_adv = 1'b0;
    pt_wr  = 1'b0;
    pt_scr = 1'b0;
    if (in_char == CH_NL) begin
      pt_col = '0;
      pt_adv = 1'b1;
    end else if (in_char == CH_TAB) begin
      pt_col = pt_col + CTW'(TAB_STEP);
    end else if (in_char != CH_CR && in_char != CH_NUL) begin
      pt_wr = 1'b1;
    end
    // Wrap a column past the last one
    if (pt_col > CTW'(COLS - 1)) begin
      pt_col = '0;
      pt_adv = 1'b1;
    end
    // Move down, or scroll at the bottom row
    if (pt_adv) begin
      if (cur_row_r == RW'(ROWS - 1)) begin
        pt_scr = 1'b1;
        pt_top = (top_r == RW'(ROWS - 1)) ? '0 : top_r + RW'(1);
      end else begin
        pt_row = cur_row_r + RW'(1);
      end
    end
  end

  // Sequencer
  always_comb begin
    state_nxt    = state_r;
    cur_row_nxt  = cur_row_r;
    cur_col_nxt  = cur_col_r;
    top_nxt      = top_r;
    ch_nxt       = ch_r;
    wr_col_nxt   = wr_col_r;
    wr_pend_nxt  = wr_pend_r;
    scr_nxt      = scr_r;
    cell_nxt     = cell_r;
    rd_zero_nxt  = rd_zero_r;
    init_nxt     = init_r;
    clr_addr_nxt = clr_addr_r;
    clr_last_nxt = clr_last_r;
    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          scr_nxt  = 1'b0;
          cell_nxt = '0;
          case (in_cmd)
            CMD_PUT: begin
              ch_nxt      = in_char;
              wr_col_nxt  = CW'(pt_col);
              wr_pend_nxt = pt_wr;
              scr_nxt     = pt_scr;
              cur_row_nxt = pt_row;
              top_nxt     = pt_top;
              cur_col_nxt = CW'(pt_col) + CW'(pt_wr);
              // Clear the row that becomes the new bottom row
              clr_addr_nxt = AW'(top_r) * AW'(COLS);
              clr_last_nxt = AW'(top_r) * AW'(COLS) + AW'(COLS - 1);
              if (pt_scr) begin
                state_nxt = ST_CLR;
              end else if (pt_wr) begin
                state_nxt = ST_WR;
              end else begin
                state_nxt = ST_DONE;
              end
            end
            CMD_READ: begin
              rd_zero_nxt = sel_col_oor;
              state_nxt   = ST_RD;
            end
            CMD_SET: begin
              cur_row_nxt = sel_row;
              cur_col_nxt = sel_col_set;
              state_nxt   = ST_DONE;
            end
            CMD_CLEAR: begin
              cur_row_nxt  = '0;
              cur_col_nxt  = '0;
              top_nxt      = '0;
              wr_pend_nxt  = 1'b0;
              clr_addr_nxt = '0;
              clr_last_nxt = AW'(DEPTH - 1);
              state_nxt    = ST_CLR;
            end
            default: begin
              state_nxt = ST_DONE;
            end
          endcase
        end
      end
      ST_CLR: begin
        clr_addr_nxt = clr_addr_r + AW'(1);
        if (clr_addr_r == clr_last_r) begin
          if (init_r) begin
            init_nxt  = 1'b0;
            state_nxt = ST_IDLE;
          end else if (wr_pend_r) begin
            state_nxt = ST_WR;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_WR: begin
        state_nxt = ST_DONE;
      end
      ST_RD: begin
        cell_nxt  = rd_zero_r ? '0 : ram_rdata;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Cell memory: sweeps write zeros, puts write the character
  assign ram_we    = (state_r == ST_CLR) || (state_r == ST_WR);
  assign ram_waddr = (state_r == ST_CLR) ? clr_addr_r : unit_addr;
  assign ram_wdata = (state_r == ST_CLR) ? CH_NUL : ch_r;

  tccs_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (unit_addr),
    .rdata (ram_rdata)
  );

  // Control and cursor registers; reset starts the clearing pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLR;
      init_r     <= 1'b1;
      cur_row_r  <= '0;
      cur_col_r  <= '0;
      top_r      <= '0;
      wr_pend_r  <= 1'b0;
      clr_addr_r <= '0;
      clr_last_r <= AW'(DEPTH - 1);
    end else begin
      state_r    <= state_nxt;
      init_r     <= init_nxt;
      cur_row_r  <= cur_row_nxt;
      cur_col_r  <= cur_col_nxt;
      top_r      <= top_nxt;
      wr_pend_r  <= wr_pend_nxt;
      clr_addr_r <= clr_addr_nxt;
      clr_last_r <= clr_last_nxt;
    end
  end

  // Item payload registers
  always_ff @(posedge clk) begin
    ch_r      <= ch_nxt;
    wr_col_r  <= wr_col_nxt;
    scr_r     <= scr_nxt;
    cell_r    <= cell_nxt;
    rd_zero_r <= rd_zero_nxt;
  end

  // Output register: load when empty or being drained
  assign out_load = (state_r == ST_DONE) && (!out_valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_cell_r <= cell_r;
      out_row_r  <= CUR_ROW_W'(cur_row_r);
      out_col_r  <= CUR_COL_W'(cur_col_r);
      out_scr_r  <= scr_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_DATA_W - OUT_FIELDS_W)'(0), out_scr_r, out_col_r,
                       out_row_r, out_cell_r};

endmodule

// ----- hdl/tccs_checker.sv -----
// Port-level checks for the text console top level, bound to it below.
// Depends on tccs_pkg for the stream widths.
module tccs_checker
  import tccs_pkg::*;
#(
  parameter int ROWS = 16,
  parameter int COLS = 64
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata
);

  localparam int ROW_LSB = CELL_W;
  localparam int COL_LSB = CELL_W + CUR_ROW_W;
  localparam int SCR_BIT = CELL_W + CUR_ROW_W + CUR_COL_W;

  // Reset starts the clearing pass with nothing in flight
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !in_tready && !out_tvalid)
    else $error("block ready or result valid right after reset");

  // One item at a time: an accepted item drops ready in the cycle after it is taken
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("item accepted while previous item still in work");

  // A scroll leaves the cursor on the bottom row and reads no cell
  a_scroll_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[SCR_BIT] |->
      out_tdata[ROW_LSB +: CUR_ROW_W] == CUR_ROW_W'(ROWS - 1) &&
      out_tdata[CELL_W-1:0] == '0)
    else $error("scrolled result with cursor off the bottom row or a cell");

  // Cursor column never passes the pending-wrap value
  a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (COLS > 127) || (int'(out_tdata[COL_LSB +: CUR_COL_W]) <= COLS))
    else $error("cursor column beyond wrap position");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed or dropped");

endmodule

bind text_console_cursor_scroll_top tccs_checker #(
  .ROWS (ROWS),
  .COLS (COLS)
) u_tccs_checker (.*);

// ----- tb/tb_text_console_cursor_scroll_top.sv -----
// Testbench for the text console block: puts, reads, cursor sets and clears.
// Self-checking against an in-file cursor and cell-store tracker; needs
// tccs_pkg and text_console_cursor_scroll_top with its tccs_ram cell memory.
`timescale 1ns / 1ps

module tb_text_console_cursor_scroll_top;
  import tccs_pkg::*;

  localparam int ROWS = 16;
  localparam int COLS = 64;
  localparam int RANDOM_ITEMS = 1625;
  localparam int STALL_LIMIT = 8000;
  localparam int HOLD_OFF_AT = 300;
  localparam int HOLD_OFF_CYCLES = 400;

  typedef struct packed {
    logic [CELL_W-1:0]    cell_char;
    logic [CUR_ROW_W-1:0] row;
    logic [CUR_COL_W-1:0] col;
    logic                 scrolled;
  } console_result_t;

  // Track cells, cursor and ring offset; queue the result of each command
  class console_scoreboard;
    logic [CHAR_W-1:0] cells [ROWS*COLS];
    int unsigned cur_col;
    int unsigned cur_row;
    int unsigned top_off;
    console_result_t expected_results [$];
    int unsigned mismatches;

    function new();
      wipe_screen();
      mismatches = 0;
    endfunction

    function void wipe_screen();
      foreach (cells[i]) cells[i] = '0;
      cur_col = 0;
      cur_row = 0;
      top_off = 0;
    endfunction

    function int unsigned store_row(int unsigned screen_row);
      return (top_off + screen_row) % ROWS;
    endfunction

    // Move down a row; at the bottom, rotate the ring and blank the new line
    function bit line_feed();
      int unsigned base;
      if (cur_row >= ROWS - 1) begin
        cur_row = ROWS - 1;
        top_off = (top_off + 1) % ROWS;
        base = store_row(ROWS - 1) * COLS;
        for (int c = 0; c < COLS; c++) cells[base + c] = '0;
        return 1'b1;
      end
      cur_row++;
      return 1'b0;
    endfunction

    function void note_command(cmd_t cmd, logic [IN_DATA_W-1:0] data);
      console_result_t r;
      logic [CHAR_W-1:0] ch;
      int unsigned rsel;
      int unsigned csel;
      bit writes;
      ch = data[7:0];
      rsel = 32'(data[11:8]);
      csel = 32'(data[17:12]);
      if (rsel > ROWS - 1) rsel = ROWS - 1;
      r = '0;
      writes = 1'b0;
      case (cmd)
        CMD_PUT: begin
          if (ch == CH_NL) begin
            cur_col = 0;
            r.scrolled |= line_feed();
          end else if (ch == CH_TAB) begin
            cur_col += TAB_STEP;
          end else if (ch != CH_CR && ch != CH_NUL) begin
            writes = 1'b1;
          end
          // Resolve a pending or overshooting column before any write
          if (cur_col > COLS - 1) begin
            cur_col = 0;
            r.scrolled |= line_feed();
          end
          if (writes) begin
            cells[store_row(cur_row) * COLS + cur_col] = ch;
            cur_col++;
          end
        end
        CMD_READ: begin
          if (csel < COLS) r.cell_char = cells[store_row(rsel) * COLS + csel];
        end
        CMD_SET: begin
          cur_row = rsel;
          cur_col = (csel > COLS - 1) ? COLS - 1 : csel;
        end
        CMD_CLEAR: begin
          wipe_screen();
        end
      endcase
      r.row = CUR_ROW_W'(cur_row);
      r.col = CUR_COL_W'(cur_col);
      expected_results.push_back(r);
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(logic [OUT_DATA_W-1:0] data);
      console_result_t want;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual %h", $time, data);
        mismatches++;
        return;
      end
      want = expected_results.pop_front();
      compare_field("cell_char", 32'(want.cell_char), 32'(data[7:0]));
      compare_field("cur_row", 32'(want.row), 32'(data[11:8]));
      compare_field("cur_col", 32'(want.col), 32'(data[18:12]));
      compare_field("scrolled", 32'(want.scrolled), 32'(data[19]));
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  // in_tdata: char_code [7:0], row_sel [11:8], col_sel [17:12], zero pad
  logic [IN_DATA_W-1:0]  in_tdata;
  // in_tuser: command [1:0]
  logic [CMD_W-1:0]      in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  // out_tdata: cell_char [7:0], cur_row [11:8], cur_col [18:12], scrolled [19]
  logic [OUT_DATA_W-1:0] out_tdata;

  console_scoreboard sb = new();
  int unsigned items_accepted = 0;
  int unsigned idle_cycles = 0;
  int unsigned burst_left = 0;

  text_console_cursor_scroll_top #(
    .ROWS(ROWS),
    .COLS(COLS)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Observe both channels; check results before noting a new command
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) sb.check_result(out_tdata);
      if (in_tvalid && in_tready) begin
        sb.note_command(cmd_t'(in_tuser), in_tdata);
        items_accepted++;
      end
    end
  end

  // Abort when neither channel has moved for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == STALL_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Stall the result side in segments of different patterns, once for long
  initial begin
    int unsigned mode;
    int unsigned seg_len;
    logic [7:0] pattern;
    bit held_off;
    held_off = 1'b0;
    out_tready <= 1'b0;
    forever begin
      if (!held_off && items_accepted >= HOLD_OFF_AT) begin
        held_off = 1'b1;
        @(posedge clk);
        out_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      mode = $urandom_range(0, 3);
      seg_len = $urandom_range(20, 200);
      pattern = 8'($urandom_range(0, 255));
      for (int i = 0; i < seg_len; i++) begin
        @(posedge clk);
        case (mode)
          0: out_tready <= 1'b1;
          1: out_tready <= pattern[i % 8];
          2: out_tready <= ($urandom_range(0, 3) != 0);
          default: out_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Offer one command and hold it until taken; drop valid between bursts
  task automatic issue_command(cmd_t cmd, logic [CHAR_W-1:0] ch,
                               logic [ROW_SEL_W-1:0] rs, logic [COL_SEL_W-1:0] cs);
    logic [IN_DATA_W-1:0] data;
    int unsigned gap;
    data = '0;
    data[7:0] = ch;
    data[11:8] = rs;
    data[17:12] = cs;
    in_tvalid <= 1'b1;
    in_tuser <= cmd;
    in_tdata <= data;
    do @(posedge clk); while (!in_tready);
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(0, 40);
    end else begin
      burst_left--;
    end
  endtask

  initial begin
    int unsigned pick;
    logic [CHAR_W-1:0] ch;
    logic [ROW_SEL_W-1:0] rs;
    logic [COL_SEL_W-1:0] cs;
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tuser <= CMD_PUT;
    in_tdata <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Plain write, high byte, tab, carriage return and zero byte
    issue_command(CMD_PUT, 8'h41, 4'hF, 6'h3F);
    issue_command(CMD_PUT, 8'hFF, 4'h0, 6'h00);
    issue_command(CMD_PUT, CH_TAB, 4'h5, 6'h2A);
    issue_command(CMD_PUT, CH_CR, 4'hA, 6'h15);
    issue_command(CMD_PUT, CH_NUL, 4'h3, 6'h11);
    issue_command(CMD_READ, 8'hFF, 4'h0, 6'h00);
    issue_command(CMD_READ, 8'h00, 4'h0, 6'h01);
    issue_command(CMD_READ, 8'h00, 4'h0, 6'h3F);
    issue_command(CMD_PUT, CH_NL, 4'h0, 6'h00);
    // Write into the last column, then let a carriage return take the wrap
    issue_command(CMD_SET, 8'hFF, 4'h0, 6'h3F);
    issue_command(CMD_PUT, 8'h5A, 4'h0, 6'h00);
    issue_command(CMD_PUT, CH_CR, 4'h0, 6'h00);
    // Tab from a pending wrap on the bottom row scrolls
    issue_command(CMD_SET, 8'h00, 4'hF, 6'h3E);
    issue_command(CMD_PUT, 8'h78, 4'h0, 6'h00);
    issue_command(CMD_PUT, 8'h79, 4'h0, 6'h00);
    issue_command(CMD_PUT, CH_TAB, 4'h0, 6'h00);
    issue_command(CMD_READ, 8'h00, 4'hE, 6'h3E);
    // Newline on the bottom row scrolls and blanks the new line
    issue_command(CMD_PUT, CH_NL, 4'h0, 6'h00);
    issue_command(CMD_READ, 8'h00, 4'hF, 6'h00);
    // Character after a pending wrap on the bottom row scrolls, then writes
    issue_command(CMD_SET, 8'h00, 4'hF, 6'h3F);
    issue_command(CMD_PUT, 8'h71, 4'h0, 6'h00);
    issue_command(CMD_PUT, 8'h72, 4'h0, 6'h00);
    issue_command(CMD_READ, 8'h00, 4'hF, 6'h00);
    issue_command(CMD_CLEAR, 8'hFF, 4'hF, 6'h3F);
    issue_command(CMD_READ, 8'h00, 4'hE, 6'h00);

    // Mostly runs of text with control bytes, sprinkled reads, moves, clears
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      pick = $urandom_range(0, 99);
      ch = 8'($urandom_range(0, 255));
      rs = 4'($urandom_range(0, 15));
      cs = 6'($urandom_range(0, 63));
      if (pick < 68) begin
        case ($urandom_range(0, 19))
          0: ch = CH_NL;
          1: ch = CH_TAB;
          2: ch = CH_CR;
          3: ch = CH_NUL;
          4, 5: ch = 8'($urandom_range(0, 255));
          default: ch = 8'($urandom_range(8'h20, 8'h7E));
        endcase
        issue_command(CMD_PUT, ch, rs, cs);
      end else if (pick < 84) begin
        if ($urandom_range(0, 1) == 0) cs = 6'($urandom_range(0, 15));
        issue_command(CMD_READ, ch, rs, cs);
      end else if (pick < 97) begin
        // Favor the bottom rows and last columns to force wraps and scrolls
        if ($urandom_range(0, 1) == 0) rs = 4'($urandom_range(12, 15));
        if ($urandom_range(0, 1) == 0) cs = 6'($urandom_range(56, 63));
        issue_command(CMD_SET, ch, rs, cs);
      end else begin
        issue_command(CMD_CLEAR, ch, rs, cs);
      end
    end
    in_tvalid <= 1'b0;

    // Drain, then watch a little longer for stray results
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (2 * COLS) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- text_console_cursor_scroll_top.f -----
hdl/tccs_pkg.sv
hdl/tccs_ram.sv
hdl/text_console_cursor_scroll_top.sv
hdl/tccs_checker.sv
tb/tb_text_console_cursor_scroll_top.sv
